/* rtl/afb_pkg.sv */
package afb_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int BYTE_W     = 8;
   localparam int GAIN_W     = 3;
   localparam int COUNT_W    = 8;
   localparam int SLOT_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_UP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_DOWN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM      = 2'd3;

   // Register values after reset.
   localparam logic [SAMPLE_W-1:0] RANGE_UP_RESET   = 16'd54000;
   localparam logic [SAMPLE_W-1:0] RANGE_DOWN_RESET = 16'd12000;
   localparam logic [COUNT_W-1:0]  CONFIRM_RESET    = 8'd3;
   localparam logic [SAMPLE_W-1:0] ALARM_RESET      = 16'd52428;

   // Frame layout: three sync characters, gain, sample high byte, sample low byte.
   localparam logic [BYTE_W-1:0] SYNC_CHAR_0 = 8'h57;
   localparam logic [BYTE_W-1:0] SYNC_CHAR_1 = 8'h53;
   localparam logic [BYTE_W-1:0] SYNC_CHAR_2 = 8'h4B;

   localparam logic [SLOT_W-1:0] SLOT_SYNC_0 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_SYNC_1 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_SYNC_2 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_GAIN   = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_HIGH   = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_LOW    = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_LOW;

   typedef struct packed {
      logic [SAMPLE_W-1:0] up_level;
      logic [SAMPLE_W-1:0] down_level;
      logic [COUNT_W-1:0]  confirm;
      logic [SAMPLE_W-1:0] alarm_level;
   } csr_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [GAIN_W-1:0]   gain_before;
      logic                alarm;
      logic [GAIN_W-1:0]   gain_after;
      logic                changed;
   } frame_type;

endpackage

/* rtl/afb_decide.sv */
module afb_decide #(
   parameter int MAX_GAIN_CODE = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  afb_pkg::csr_type              csr,
   input  logic                          load,
   input  logic [afb_pkg::SAMPLE_W-1:0]  sample,
   output afb_pkg::frame_type            frame
);
   import afb_pkg::*;

   localparam logic [GAIN_W-1:0] GAIN_TOP = GAIN_W'(MAX_GAIN_CODE);

   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [COUNT_W-1:0] up_count_ff, up_count_in;
   logic [COUNT_W-1:0] down_count_ff, down_count_in;
   logic               up_request, down_request, changed;
   logic [COUNT_W-1:0] up_bumped, down_bumped;

   always_comb begin
      up_request   = (sample > csr.up_level) && (gain_ff != '0);
      down_request = (sample < csr.down_level) && (gain_ff < GAIN_TOP);
      up_bumped    = (up_count_ff == '1) ? up_count_ff : up_count_ff + 1'b1;
      down_bumped  = (down_count_ff == '1) ? down_count_ff : down_count_ff + 1'b1;

      gain_in       = gain_ff;
      up_count_in   = up_count_ff;
      down_count_in = down_count_ff;
      changed       = 1'b0;

      // The counters are deliberately left alone after a gain step.
      if (up_request) begin
         up_count_in = up_bumped;
         if (up_bumped >= csr.confirm) begin
            gain_in = gain_ff - 1'b1;
            changed = 1'b1;
         end
      end else if (down_request) begin
         down_count_in = down_bumped;
         if (down_bumped >= csr.confirm) begin
            gain_in = gain_ff + 1'b1;
            changed = 1'b1;
         end
      end else begin
         up_count_in   = '0;
         down_count_in = '0;
      end

      frame.sample      = sample;
      frame.gain_before = gain_ff;
      frame.alarm       = (sample > csr.alarm_level) && (gain_ff == '0);
      frame.gain_after  = gain_in;
      frame.changed     = changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= '0;
         up_count_ff   <= '0;
         down_count_ff <= '0;
      end else if (load) begin
         gain_ff       <= gain_in;
         up_count_ff   <= up_count_in;
         down_count_ff <= down_count_in;
      end
   end

endmodule

/* rtl/afb_serial.sv */
module afb_serial (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  afb_pkg::frame_type           load_frame,
   output logic                         free,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [afb_pkg::BYTE_W-1:0]   rsp_frame_byte,
   output logic                         rsp_last_byte,
   output logic                         rsp_alarm,
   output logic [afb_pkg::GAIN_W-1:0]   rsp_gain_code,
   output logic                         rsp_gain_changed
);
   import afb_pkg::*;

   logic              busy_ff, busy_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   frame_type         frame_ff;
   logic              transfer, done;

   assign transfer = busy_ff && !rsp_stall;
   assign done     = transfer && (slot_ff == SLOT_LAST);
   assign free     = !busy_ff || done;

   always_comb begin
      busy_in = busy_ff;
      slot_in = slot_ff;
      if (load) begin
         busy_in = 1'b1;
         slot_in = SLOT_SYNC_0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (transfer) begin
         slot_in = slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= SLOT_SYNC_0;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= load_frame;
      end
   end

   always_comb begin
      case (slot_ff)
         SLOT_SYNC_0: rsp_frame_byte = SYNC_CHAR_0;
         SLOT_SYNC_1: rsp_frame_byte = SYNC_CHAR_1;
         SLOT_SYNC_2: rsp_frame_byte = SYNC_CHAR_2;
         SLOT_GAIN:   rsp_frame_byte = BYTE_W'(1) << frame_ff.gain_before;
         SLOT_HIGH:   rsp_frame_byte = frame_ff.sample[SAMPLE_W-1:BYTE_W];
         default:     rsp_frame_byte = frame_ff.sample[BYTE_W-1:0];
      endcase
   end

   assign rsp_valid        = busy_ff;
   assign rsp_last_byte    = (slot_ff == SLOT_LAST);
   assign rsp_alarm        = frame_ff.alarm;
   assign rsp_gain_code    = frame_ff.gain_after;
   assign rsp_gain_changed = frame_ff.changed;

endmodule

/* rtl/adc_autorange_frame_builder_top.sv */
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_sample (16 bit ADC result)
// rsp      out        rsp_valid/rsp_stall  frame byte, last flag, alarm, gain code, change flag
// csr      in         csr_write_enable     csr_index, csr_write_data (write only)
//
// Each sample yields six byte transfers on rsp, so the sustained sample rate is set by the
// single byte-wide result port. The gain decision is made as a held sample moves into the
// frame register; its first byte is offered once the sample has passed the input and frame registers.
// Reset is synchronous and active high; it restores the configuration registers, the gain code
// and both qualification counters. A stall on rsp holds the current byte; one further sample
// may be taken meanwhile and waits in the input register, after which req_stall is raised.
module adc_autorange_frame_builder_top #(
   parameter int MAX_GAIN_CODE = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [afb_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [afb_pkg::BYTE_W-1:0]      rsp_frame_byte,
   output logic                            rsp_last_byte,
   output logic                            rsp_alarm,
   output logic [afb_pkg::GAIN_W-1:0]      rsp_gain_code,
   output logic                            rsp_gain_changed,
   input  logic                            csr_write_enable,
   input  logic [afb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [afb_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import afb_pkg::*;

   csr_type             csr_ff;
   logic                hold_valid_ff, hold_valid_in;
   logic [SAMPLE_W-1:0] hold_sample_ff;
   logic                serial_free, load, req_transfer;
   frame_type           decided;

   // Configuration registers. An index with no register behind it cannot occur
   // with a two-bit index, so every write lands somewhere.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.up_level    <= RANGE_UP_RESET;
         csr_ff.down_level  <= RANGE_DOWN_RESET;
         csr_ff.confirm     <= CONFIRM_RESET;
         csr_ff.alarm_level <= ALARM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RANGE_UP:   csr_ff.up_level    <= csr_write_data;
            CSR_RANGE_DOWN: csr_ff.down_level  <= csr_write_data;
            CSR_CONFIRM:    csr_ff.confirm     <= csr_write_data[COUNT_W-1:0];
            CSR_ALARM:      csr_ff.alarm_level <= csr_write_data;
            default:        ;
         endcase
      end
   end

   // The held sample moves on as soon as the serialiser can take a new frame,
   // which includes the cycle in which the previous frame's last byte is transferred.
   assign load         = hold_valid_ff && serial_free;
   assign req_stall    = hold_valid_ff && !serial_free;
   assign req_transfer = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_transfer) begin
         hold_valid_in = 1'b1;
      end else if (load) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         hold_sample_ff <= req_sample;
      end
   end

   afb_decide #(
      .MAX_GAIN_CODE (MAX_GAIN_CODE)
   ) u_decide (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr_ff),
      .load   (load),
      .sample (hold_sample_ff),
      .frame  (decided)
   );

   afb_serial u_serial (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .load_frame       (decided),
      .free             (serial_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_alarm        (rsp_alarm),
      .rsp_gain_code    (rsp_gain_code),
      .rsp_gain_changed (rsp_gain_changed)
   );

endmodule

/* rtl/afb_checker.sv */
module afb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [afb_pkg::BYTE_W-1:0]    rsp_frame_byte,
   input logic                          rsp_last_byte,
   input logic                          rsp_alarm,
   input logic [afb_pkg::GAIN_W-1:0]    rsp_gain_code,
   input logic                          rsp_gain_changed
);
   import afb_pkg::*;

   logic [SLOT_W-1:0] byte_count_ff;
   logic              rsp_transfer;

   assign rsp_transfer = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= SLOT_SYNC_0;
      end else if (rsp_transfer) begin
         byte_count_ff <= rsp_last_byte ? SLOT_SYNC_0 : byte_count_ff + 1'b1;
      end
   end

   a_last_on_sixth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_byte == (byte_count_ff == SLOT_LAST)))
      else $error("last byte flag out of step with the byte count");

   a_frame_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && byte_count_ff == SLOT_SYNC_0 |-> rsp_frame_byte == SYNC_CHAR_0)
      else $error("frame does not open with its sync character");

   a_frame_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_transfer && !rsp_last_byte |=> rsp_valid && $stable(rsp_alarm)
         && $stable(rsp_gain_code) && $stable(rsp_gain_changed))
      else $error("frame broken up or its status changed mid-frame");

   a_alarm_gain_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alarm && byte_count_ff == SLOT_GAIN |-> rsp_frame_byte == 8'h01)
      else $error("alarm reported at a gain other than one");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte))
      else $error("stalled result byte changed");

endmodule

bind adc_autorange_frame_builder_top afb_checker u_afb_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frame_byte   (rsp_frame_byte),
   .rsp_last_byte    (rsp_last_byte),
   .rsp_alarm        (rsp_alarm),
   .rsp_gain_code    (rsp_gain_code),
   .rsp_gain_changed (rsp_gain_changed)
);
